// File: rtl/core/saf_pkg.sv
package saf_pkg;

	// Fixed field widths
	localparam int SYM_W = 7;
	localparam int POS_W = 32;

	// Input mode codes
	localparam logic [1:0] MODE_PATTERN = 2'd0;
	localparam logic [1:0] MODE_TEXT    = 2'd1;
	localparam logic [1:0] MODE_CLEAR   = 2'd2;

	// Queue depths between front, back and the result port
	localparam int CMD_DEPTH = 4;
	localparam int RES_DEPTH = 4;

	typedef struct packed {
		logic [1:0]       mode;
		logic [SYM_W-1:0] symbol;
	} item_t;

	typedef struct packed {
		logic             found;
		logic [POS_W-1:0] start_index;
	} result_t;

	// Classified command from the front
	typedef enum logic [1:0] {
		CMD_PATTERN,
		CMD_TEXT,
		CMD_CLEAR
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t        kind;
		logic [SYM_W-1:0] sym;
		logic             active;  // pattern is not empty
		logic             evict;   // window full, oldest symbol leaves
		logic             cand;    // window full after this symbol
		logic [POS_W-1:0] start;
	} cmd_t;

	// One read-modify-write slot of the count difference memory
	typedef enum logic [1:0] {
		OP_NOP,
		OP_UPD,
		OP_CLR
	} op_kind_t;

	typedef struct packed {
		op_kind_t         kind;
		logic             inc;
		logic [SYM_W-1:0] addr;
		logic             report;
		logic             cand;
		logic [POS_W-1:0] start;
	} op_t;

endpackage

// File: rtl/core/saf_queue.sv
module saf_queue import saf_pkg::*; #(
	parameter int W     = 8,
	parameter int DEPTH = 4
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] wdata,
	input  logic         pop,
	output logic [W-1:0] rdata,
	output logic         not_empty,
	output logic         full
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [W-1:0]     mem [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign not_empty = (count_q != '0);
	assign full      = (count_q == CNT_W'(DEPTH));
	assign rdata     = mem[rd_ptr_q];

	// Store the pushed beat
	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= wdata;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (!push && pop) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

// File: rtl/core/saf_front.sv
module saf_front import saf_pkg::*; #(
	parameter int MAX_PATTERN = 256,
	parameter int ALPHABET    = 128,
	parameter int SLOT_W      = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  item_t             item,
	input  logic              cmd_full,
	output logic              cmd_push,
	output cmd_t              cmd,
	output logic [SLOT_W-1:0] slot
);

	localparam int LW = $clog2(MAX_PATTERN + 1);

	logic              started_q;
	logic [LW-1:0]     plen_q;
	logic [LW-1:0]     fill_q;
	logic [SLOT_W-1:0] rp_q;
	logic [POS_W-1:0]  pos_q;

	logic              accept;
	logic [SYM_W-1:0]  sym_f;
	logic [LW-1:0]     fill_inc;
	logic              pat_take;
	logic              full_win;

	assign item_stall = cmd_full;
	assign accept     = item_valid && !cmd_full;
	assign fill_inc   = fill_q + LW'(1);
	assign full_win   = (fill_q == plen_q);
	assign pat_take   = !started_q && (plen_q < LW'(MAX_PATTERN));
	assign slot       = rp_q;

	// Saturate codes outside the alphabet
	always_comb begin
		if (int'(item.symbol) >= ALPHABET) begin
			sym_f = SYM_W'(ALPHABET - 1);
		end else begin
			sym_f = item.symbol;
		end
	end

	// Classify the beat into a back-end command
	always_comb begin
		cmd      = '0;
		cmd.sym  = sym_f;
		cmd_push = 1'b0;
		case (item.mode)
			MODE_PATTERN: begin
				cmd.kind = CMD_PATTERN;
				cmd_push = accept && pat_take;
			end
			MODE_TEXT: begin
				cmd.kind   = CMD_TEXT;
				cmd.active = (plen_q != '0);
				cmd.evict  = cmd.active && full_win;
				cmd.cand   = cmd.active && (full_win || (fill_inc == plen_q));
				cmd.start  = pos_q - POS_W'(plen_q) + POS_W'(1);
				cmd_push   = accept;
			end
			MODE_CLEAR: begin
				cmd.kind = CMD_CLEAR;
				cmd_push = accept;
			end
			default: begin
				cmd_push = 1'b0;
			end
		endcase
	end

	// Track pattern length, window fill, ring slot and text position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q <= 1'b0;
			plen_q    <= '0;
			fill_q    <= '0;
			rp_q      <= '0;
			pos_q     <= '0;
		end else if (accept) begin
			case (item.mode)
				MODE_PATTERN: begin
					if (pat_take) begin
						plen_q <= plen_q + LW'(1);
					end
				end
				MODE_TEXT: begin
					started_q <= 1'b1;
					pos_q     <= pos_q + POS_W'(1);
					if (plen_q != '0) begin
						if (!full_win) begin
							fill_q <= fill_inc;
						end
						rp_q <= (LW'(rp_q) + LW'(1) >= plen_q) ? '0 : rp_q + SLOT_W'(1);
					end
				end
				MODE_CLEAR: begin
					started_q <= 1'b0;
					plen_q    <= '0;
					fill_q    <= '0;
					rp_q      <= '0;
					pos_q     <= '0;
				end
				default: begin
					started_q <= started_q;
				end
			endcase
		end
	end

endmodule

// File: rtl/core/saf_back.sv
module saf_back import saf_pkg::*; #(
	parameter int MAX_PATTERN = 256,
	parameter int ALPHABET    = 128,
	parameter int SLOT_W      = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	input  cmd_t              cmd,
	input  logic [SLOT_W-1:0] slot,
	output logic              cmd_pop,
	output logic              res_push,
	output result_t           res,
	input  logic              res_pop
);

	localparam int AW = $clog2(ALPHABET);
	localparam int DW = $clog2(MAX_PATTERN + 1) + 1;
	localparam int MW = $clog2(ALPHABET + 1);
	localparam int CW = $clog2(RES_DEPTH + 1);

	// Ring of window symbols
	logic [SYM_W-1:0] ring_mem [MAX_PATTERN];
	logic [SYM_W-1:0] ring_rd_q;
	logic             ring_we;

	// Pending leave update of a full-window text symbol
	logic             pend_q;
	logic             pend_cand_q;
	logic [POS_W-1:0] pend_start_q;

	// Pattern minus window count per code, entries valid since last clear
	logic [DW-1:0]       dmem [ALPHABET];
	logic [ALPHABET-1:0] vld_q;
	logic [DW-1:0]       rd_s1;
	logic                vbit_s1;

	logic             fw_upd_q;
	logic             fw_clr_q;
	logic [SYM_W-1:0] fw_addr_q;
	logic [DW-1:0]    fw_data_q;

	logic [MW-1:0] mismatch_q;
	logic [CW-1:0] credit_q;

	op_t           op;
	op_t           op_s1;
	op_t           op_s2;
	logic          is_text;
	logic          take;
	logic [DW-1:0] old_s1;
	logic [DW-1:0] new_s1;

	// Dispatch: a text symbol reserves a result slot
	assign is_text = (cmd.kind == CMD_TEXT);
	assign cmd_pop = cmd_valid && !pend_q && (!is_text || (credit_q != '0));
	assign take    = cmd_pop && is_text;
	assign ring_we = take && cmd.active;

	always_comb begin
		op = '0;
		if (pend_q) begin
			op.kind   = OP_UPD;
			op.inc    = 1'b1;
			op.addr   = ring_rd_q;
			op.report = 1'b1;
			op.cand   = pend_cand_q;
			op.start  = pend_start_q;
		end else if (cmd_pop) begin
			case (cmd.kind)
				CMD_PATTERN: begin
					op.kind = OP_UPD;
					op.inc  = 1'b1;
					op.addr = cmd.sym;
				end
				CMD_TEXT: begin
					op.report = !(cmd.active && cmd.evict);
					op.cand   = cmd.cand;
					op.start  = cmd.start;
					if (cmd.active) begin
						op.kind = OP_UPD;
						op.inc  = 1'b0;
						op.addr = cmd.sym;
					end
				end
				CMD_CLEAR: begin
					op.kind = OP_CLR;
				end
				default: begin
					op.kind = OP_NOP;
				end
			endcase
		end
	end

	// Read the leaving symbol and write the entering one in the same slot
	always_ff @(posedge clk) begin
		if (ring_we) begin
			ring_rd_q      <= ring_mem[slot];
			ring_mem[slot] <= cmd.sym;
		end
		if (take) begin
			pend_cand_q  <= cmd.cand;
			pend_start_q <= cmd.start;
		end
	end

	// Hold the dispatcher in the cycle after an evicting text symbol for its leave update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 1'b0;
		end else begin
			pend_q <= ring_we && cmd.evict;
		end
	end

	// Forward the previous write, which the registered read missed
	always_comb begin
		if (fw_clr_q) begin
			old_s1 = '0;
		end else if (fw_upd_q && (fw_addr_q == op_s1.addr)) begin
			old_s1 = fw_data_q;
		end else if (vbit_s1) begin
			old_s1 = rd_s1;
		end else begin
			old_s1 = '0;
		end
		new_s1 = op_s1.inc ? old_s1 + DW'(1) : old_s1 - DW'(1);
	end

	// Count memory: registered read, write back from stage op_s1
	always_ff @(posedge clk) begin
		rd_s1     <= dmem[AW'(op.addr)];
		vbit_s1   <= vld_q[AW'(op.addr)];
		fw_addr_q <= op_s1.addr;
		fw_data_q <= new_s1;
		if (op_s1.kind == OP_UPD) begin
			dmem[AW'(op_s1.addr)] <= new_s1;
		end
	end

	// Advance the update pipeline, valid bits and mismatch count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_s1      <= '0;
			op_s2      <= '0;
			vld_q      <= '0;
			fw_upd_q   <= 1'b0;
			fw_clr_q   <= 1'b0;
			mismatch_q <= '0;
		end else begin
			op_s1    <= op;
			op_s2    <= op_s1;
			fw_upd_q <= (op_s1.kind == OP_UPD);
			fw_clr_q <= (op_s1.kind == OP_CLR);
			if (op_s1.kind == OP_CLR) begin
				vld_q      <= '0;
				mismatch_q <= '0;
			end else if (op_s1.kind == OP_UPD) begin
				vld_q[AW'(op_s1.addr)] <= 1'b1;
				if ((old_s1 != '0) && (new_s1 == '0)) begin
					mismatch_q <= mismatch_q - MW'(1);
				end else if ((old_s1 == '0) && (new_s1 != '0)) begin
					mismatch_q <= mismatch_q + MW'(1);
				end
			end
		end
	end

	// Report once the last update of a text symbol has landed
	assign res_push        = op_s2.report;
	assign res.found       = op_s2.cand && (mismatch_q == '0);
	assign res.start_index = res.found ? op_s2.start : '0;

	// Return result slots as the port drains
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			credit_q <= CW'(RES_DEPTH);
		end else if (take && !res_pop) begin
			credit_q <= credit_q - CW'(1);
		end else if (!take && res_pop) begin
			credit_q <= credit_q + CW'(1);
		end
	end

endmodule

// File: rtl/core/sliding_anagram_finder_top.sv
// A text result is pushed from stage op_s2, on a full window by the leave update behind it.
// Throughput: one beat per cycle while the command queue has room; a full-window text beat holds
// the dispatcher for its leave update: both updates share the count memory's single write port.
// Reset: arst_n clears all control state and the count valid bits at once; no clearing pass.
// A clear beat empties every store in one update slot.
module sliding_anagram_finder_top import saf_pkg::*; #(
	parameter int MAX_PATTERN = 256,
	parameter int ALPHABET    = 128
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	output logic    item_stall,
	input  item_t   item,
	output logic    result_valid,
	input  logic    result_stall,
	output result_t result
);

	localparam int SLOT_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
	localparam int CMD_W  = $bits(cmd_t) + SLOT_W;
	localparam int RES_W  = $bits(result_t);

	logic              cmd_push;
	logic              cmd_full;
	logic              cmd_valid;
	logic              cmd_pop;
	cmd_t              cmd_in;
	cmd_t              cmd_out;
	logic [SLOT_W-1:0] slot_in;
	logic [SLOT_W-1:0] slot_out;
	logic [CMD_W-1:0]  cmd_rdata;

	logic              res_push;
	logic              res_full;
	logic              res_pop;
	result_t           res_in;
	logic [RES_W-1:0]  res_rdata;

	saf_front #(
		.MAX_PATTERN (MAX_PATTERN),
		.ALPHABET    (ALPHABET),
		.SLOT_W      (SLOT_W)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.cmd_full   (cmd_full),
		.cmd_push   (cmd_push),
		.cmd        (cmd_in),
		.slot       (slot_in)
	);

	saf_queue #(
		.W     (CMD_W),
		.DEPTH (CMD_DEPTH)
	) u_cmd_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (cmd_push),
		.wdata     ({cmd_in, slot_in}),
		.pop       (cmd_pop),
		.rdata     (cmd_rdata),
		.not_empty (cmd_valid),
		.full      (cmd_full)
	);

	assign {cmd_out, slot_out} = cmd_rdata;

	saf_back #(
		.MAX_PATTERN (MAX_PATTERN),
		.ALPHABET    (ALPHABET),
		.SLOT_W      (SLOT_W)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd_out),
		.slot      (slot_out),
		.cmd_pop   (cmd_pop),
		.res_push  (res_push),
		.res       (res_in),
		.res_pop   (res_pop)
	);

	assign res_pop = result_valid && !result_stall;

	saf_queue #(
		.W     (RES_W),
		.DEPTH (RES_DEPTH)
	) u_res_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_push),
		.wdata     (res_in),
		.pop       (res_pop),
		.rdata     (res_rdata),
		.not_empty (result_valid),
		.full      (res_full)
	);

	assign result = result_t'(res_rdata);

	// Front never pushes into a full command queue
	a_cmd_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_push |-> !cmd_full)
		else $error("command queue overflow");

	// Result credits keep the result queue from overflowing
	a_res_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		res_push && !res_pop |-> !res_full)
		else $error("result queue overflow");

	// Back end only dequeues a present command
	a_cmd_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |-> cmd_valid)
		else $error("command pop on empty queue");

	// A miss carries a zero start index
	a_miss_zero_start: assert property (@(posedge clk) disable iff (!arst_n)
		res_push && !res_in.found |-> res_in.start_index == '0)
		else $error("nonzero start index on a miss");

endmodule

// File: tb/tb_top.sv
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import saf_pkg::*;

	localparam int MAX_PATTERN = 256;
	localparam int ALPHABET    = 128;
	localparam logic [1:0] MODE_UNUSED = 2'd3;
	localparam int ITEM_TARGET = 1750;

	logic    clk          = 1'b0;
	logic    arst_n       = 1'b0;
	logic    item_valid   = 1'b0;
	logic    item_stall;
	item_t   item         = '0;
	logic    result_valid;
	logic    result_stall = 1'b0;
	result_t result;

	sliding_anagram_finder_top #(
		.MAX_PATTERN(MAX_PATTERN),
		.ALPHABET(ALPHABET)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Symbols waiting to be sent, and window results still owed by the block
	item_t       pend_q[$];
	result_t     due_q[$];
	int unsigned total_items = 0;
	int unsigned items_taken = 0;
	int unsigned bad_beats   = 0;
	bit          hold_off    = 1'b0;

	// Shadow state of the anagram search
	logic [15:0] pat_cnt[ALPHABET];
	logic [15:0] win_cnt[ALPHABET];
	logic [6:0]  ring_sym[MAX_PATTERN];
	int unsigned ring_ptr;
	int unsigned pat_len;
	int unsigned win_fill;
	int unsigned diff_codes;
	logic [31:0] text_pos;
	bit          text_seen;

	function automatic void clear_search();
		for (int i = 0; i < ALPHABET; i++) begin
			pat_cnt[i] = '0;
			win_cnt[i] = '0;
		end
		ring_ptr   = 0;
		pat_len    = 0;
		win_fill   = 0;
		diff_codes = 0;
		text_pos   = '0;
		text_seen  = 1'b0;
	endfunction

	// Move one count and keep the number of differing codes in step
	function automatic void adjust_count(bit in_window, logic [6:0] s, bit up);
		bit was_diff;
		bit now_diff;
		was_diff = pat_cnt[s] != win_cnt[s];
		if (!in_window) begin
			pat_cnt[s] = pat_cnt[s] + 16'd1;
		end else if (up) begin
			win_cnt[s] = win_cnt[s] + 16'd1;
		end else begin
			win_cnt[s] = win_cnt[s] - 16'd1;
		end
		now_diff = pat_cnt[s] != win_cnt[s];
		if (was_diff && !now_diff) begin
			diff_codes--;
		end else if (!was_diff && now_diff) begin
			diff_codes++;
		end
	endfunction

	// Apply one accepted beat to the shadow state; text beats owe one result
	function automatic void search_step(item_t it);
		result_t     r;
		int unsigned slot;
		logic [6:0]  s;
		s = it.symbol;
		case (it.mode)
			MODE_CLEAR: begin
				clear_search();
			end
			MODE_PATTERN: begin
				if (!text_seen && pat_len < MAX_PATTERN) begin
					adjust_count(1'b0, s, 1'b1);
					pat_len++;
				end
			end
			MODE_TEXT: begin
				text_seen     = 1'b1;
				r.found       = 1'b0;
				r.start_index = '0;
				if (pat_len != 0) begin
					slot = ring_ptr % MAX_PATTERN;
					if (win_fill == pat_len) begin
						adjust_count(1'b1, ring_sym[slot], 1'b0);
					end else begin
						win_fill++;
					end
					ring_sym[slot] = s;
					adjust_count(1'b1, s, 1'b1);
					ring_ptr = (ring_ptr + 1 >= pat_len) ? 0 : ring_ptr + 1;
					if (win_fill == pat_len && diff_codes == 0) begin
						r.found       = 1'b1;
						r.start_index = text_pos - 32'(pat_len - 1);
					end
				end
				text_pos = text_pos + 32'd1;
				due_q.insert(due_q.size(), r);
			end
			default: begin
			end
		endcase
	endfunction

	// Gap length: mostly none or short, a few long, with calm stretches of none
	function automatic int unsigned next_gap(inout int unsigned calm);
		int unsigned r;
		if (calm != 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 99) == 0) begin
			calm = $urandom_range(30, 80);
		end
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	task automatic put(logic [1:0] m, logic [6:0] s);
		item_t it;
		it.mode   = m;
		it.symbol = s;
		pend_q.insert(pend_q.size(), it);
	endtask

	// Fill the send queue: directed checks, then random searches
	initial begin : gen_stimulus
		int unsigned n_counted;
		int unsigned plen;
		int unsigned tlen;
		int unsigned base;
		int unsigned span;
		int unsigned k;
		bit          big_done;
		n_counted = 0;
		big_done  = 1'b0;

		clear_search();

		// Short pattern, overlapping anagram windows, late pattern, unused mode
		put(MODE_CLEAR, 7'd0);
		put(MODE_PATTERN, 7'd97);
		put(MODE_PATTERN, 7'd98);
		put(MODE_PATTERN, 7'd99);
		put(MODE_TEXT, 7'd99);
		put(MODE_TEXT, 7'd97);
		put(MODE_TEXT, 7'd98);
		put(MODE_TEXT, 7'd97);
		put(MODE_TEXT, 7'd99);
		put(MODE_TEXT, 7'd98);
		put(MODE_PATTERN, 7'd122);
		put(MODE_UNUSED, 7'd127);
		put(MODE_TEXT, 7'd0);
		put(MODE_TEXT, 7'd127);
		// Empty pattern still advances the position
		put(MODE_CLEAR, 7'd127);
		put(MODE_TEXT, 7'd5);
		// Extreme codes, with a short window before the first match
		put(MODE_CLEAR, 7'd0);
		put(MODE_PATTERN, 7'd127);
		put(MODE_PATTERN, 7'd0);
		put(MODE_TEXT, 7'd0);
		put(MODE_TEXT, 7'd127);
		put(MODE_TEXT, 7'd127);
		n_counted = pend_q.size();

		while (n_counted < ITEM_TARGET) begin
			k = $urandom_range(0, 99);
			if (!big_done && n_counted > 600) begin
				// Pattern overflow on a full-size window over two codes
				big_done = 1'b1;
				base = $urandom_range(0, 127);
				put(MODE_CLEAR, 7'($urandom));
				for (int i = 0; i < MAX_PATTERN + 4; i++) begin
					put(MODE_PATTERN, 7'(base + $urandom_range(0, 1)));
				end
				for (int i = 0; i < 300; i++) begin
					put(MODE_TEXT, 7'(base + $urandom_range(0, 1)));
				end
				n_counted += 1 + MAX_PATTERN + 300;
			end else if (k < 85) begin
				// Search over a narrow set of codes, with an occasional unused or late pattern beat in the text
				if ($urandom_range(0, 9) != 0) begin
					put(MODE_CLEAR, 7'($urandom));
					n_counted++;
				end
				plen = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 6);
				base = $urandom_range(0, 127);
				span = $urandom_range(1, 4);
				for (int i = 0; i < plen; i++) begin
					put(MODE_PATTERN, 7'(base + $urandom_range(0, span - 1)));
				end
				tlen = $urandom_range(plen, 4 * plen + 8);
				for (int i = 0; i < tlen; i++) begin
					if ($urandom_range(0, 19) == 0) begin
						put($urandom_range(0, 1) ? MODE_UNUSED : MODE_PATTERN, 7'($urandom));
					end else begin
						put(MODE_TEXT, 7'(base + $urandom_range(0, span - 1)));
					end
				end
				n_counted += plen + tlen;
			end else begin
				// Noise over all modes and codes
				for (int i = 0; i < $urandom_range(1, 8); i++) begin
					put(2'($urandom_range(0, 3)), 7'($urandom));
				end
				n_counted += 4;
			end
		end
		total_items = pend_q.size();
	end

	// Send beats from the queue; hold the payload while stalled
	int unsigned send_gap  = 0;
	int unsigned send_calm = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if (item_valid && !item_stall) begin
				search_step(item);
				items_taken++;
			end
			if (!item_valid || !item_stall) begin
				if (send_gap != 0) begin
					item_valid <= 1'b0;
					send_gap--;
				end else if (pend_q.size() != 0) begin
					item       <= pend_q.pop_front();
					item_valid <= 1'b1;
					send_gap   = next_gap(send_calm);
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	// Check result beats against the oldest owed result; drive random stall
	int unsigned stall_left = 0;
	int unsigned stall_calm = 0;

	always @(posedge clk) begin
		result_t owed;
		if (arst_n) begin
			if (result_valid && !result_stall) begin
				if (due_q.size() == 0) begin
					bad_beats++;
					if (bad_beats <= 10) begin
						$display("unexpected result beat: found=%0d start_index=%0d",
							result.found, result.start_index);
					end
				end else begin
					owed = due_q.pop_front();
					if (result.found !== owed.found ||
						result.start_index !== owed.start_index) begin
						bad_beats++;
						if (bad_beats <= 10) begin
							$display({"result mismatch: expected found=%0d start_index=%0d,",
								" got found=%0d start_index=%0d"},
								owed.found, owed.start_index,
								result.found, result.start_index);
						end
					end
				end
			end
			if (hold_off) begin
				result_stall <= 1'b1;
			end else if (stall_left != 0) begin
				result_stall <= 1'b1;
				stall_left--;
			end else begin
				result_stall <= 1'b0;
				stall_left = next_gap(stall_calm);
			end
		end
	end

	// Hold off the receiver for a long stretch so the block backs up
	initial begin
		while (items_taken < 500) @(posedge clk);
		hold_off <= 1'b1;
		repeat (300) @(posedge clk);
		hold_off <= 1'b0;
	end

	// Reset, then drain and decide
	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		while (items_taken != total_items) @(posedge clk);
		while (due_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (bad_beats == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule

// File: sliding_anagram_finder_top.f
rtl/core/saf_pkg.sv
rtl/core/saf_queue.sv
rtl/core/saf_front.sv
rtl/core/saf_back.sv
rtl/core/sliding_anagram_finder_top.sv
tb/tb_top.sv
